// ----- sv/srcb_pkg.sv -----
// Shared types and constants for the SATA read command builder.
// Used by srcb_ctrl, srcb_dp and the top level; depends on nothing.
`timescale 1ns / 1ps

package srcb_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_BAD_COUNT = 2'd2
  } status_e;

  // Fixed field widths
  localparam int unsigned LBA_W    = 48;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned EIDX_W   = 3;
  localparam int unsigned ETOT_W   = 4;
  localparam int unsigned BCL1_W   = 13;

  // Descriptor table size; tied to the entry_index and entry_total widths
  localparam int unsigned MAX_ENTRIES = 8;

  // Chunk geometry: 16 sectors of 512 bytes
  localparam int unsigned CHUNK_SHIFT  = 4;
  localparam int unsigned SECTOR_SHIFT = 9;
  localparam logic [ADDR_W-1:0] CHUNK_BYTES = ADDR_W'(1 << (CHUNK_SHIFT + SECTOR_SHIFT));

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // latch a new request
    logic advance;  // step to the next descriptor
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;     // current descriptor is the final one
  } sts_t;

endpackage

// ----- sv/srcb_ctrl.sv -----
// Controller for the SATA read command builder: accept / emit sequencing.
// Depends on srcb_pkg for the command and status structs.
`timescale 1ns / 1ps

module srcb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output srcb_pkg::cmd_t cmd_o,
  input  srcb_pkg::sts_t sts_i
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d     = S_EMIT;
          out_valid_d = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_ready_i && sts_i.last) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;

  // Datapath commands
  assign cmd_o.load    = in_ready_o && in_valid_i;
  assign cmd_o.advance = out_valid_q && out_ready_i && !sts_i.last;

endmodule

// ----- sv/srcb_dp.sv -----
// Datapath for the SATA read command builder: slot search, count check,
// descriptor registers and address stepping. Depends on srcb_pkg.
`timescale 1ns / 1ps

module srcb_dp #(
  parameter int unsigned SLOT_COUNT  = 32
) (
  input  logic                              clk_i,
  input  srcb_pkg::cmd_t                    cmd_i,
  output srcb_pkg::sts_t                    sts_o,
  input  logic [srcb_pkg::LBA_W-1:0]        lba_start_i,
  input  logic [srcb_pkg::COUNT_W-1:0]      num_sectors_i,
  input  logic [srcb_pkg::ADDR_W-1:0]       dest_address_i,
  input  logic [srcb_pkg::MASK_W-1:0]       active_slots_i,
  input  logic [srcb_pkg::MASK_W-1:0]       issued_slots_i,
  output srcb_pkg::status_e                 status_o,
  output logic [srcb_pkg::SLOT_W-1:0]       slot_o,
  output logic [srcb_pkg::EIDX_W-1:0]       entry_index_o,
  output logic [srcb_pkg::ETOT_W-1:0]       entry_total_o,
  output logic [srcb_pkg::ADDR_W-1:0]       data_address_o,
  output logic [srcb_pkg::BCL1_W-1:0]       byte_count_less_one_o,
  output logic [srcb_pkg::LBA_W-1:0]        block_address_o,
  output logic [srcb_pkg::COUNT_W-1:0]      frame_count_o
);

  localparam int unsigned IDX_W       = $clog2(srcb_pkg::MAX_ENTRIES + 1);
  localparam int unsigned MAX_SECTORS = srcb_pkg::MAX_ENTRIES << srcb_pkg::CHUNK_SHIFT;

  // Lowest free slot: isolate the lowest set bit of the free mask, then encode
  logic [SLOT_COUNT-1:0]       free_mask, free_low;
  logic [srcb_pkg::SLOT_W-1:0] slot_enc;
  logic                        slot_found;

  assign free_mask  = ~(active_slots_i[SLOT_COUNT-1:0] | issued_slots_i[SLOT_COUNT-1:0]);
  assign free_low   = free_mask & (~free_mask + SLOT_COUNT'(1));
  assign slot_found = |free_mask;

  always_comb begin
    slot_enc = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (free_low[i]) slot_enc = slot_enc | srcb_pkg::SLOT_W'(i);
    end
  end

  // Count check and descriptor total
  logic                         count_ok, req_ok;
  logic [srcb_pkg::COUNT_W-1:0] count_m1;
  logic [IDX_W-1:0]             total_calc;

  assign count_ok   = (num_sectors_i != '0) &&
                      (32'(num_sectors_i) <= 32'(MAX_SECTORS));
  assign req_ok     = slot_found && count_ok;
  assign count_m1   = num_sectors_i - srcb_pkg::COUNT_W'(1);
  assign total_calc = IDX_W'(count_m1 >> srcb_pkg::CHUNK_SHIFT) + IDX_W'(1);

  // Request and descriptor registers
  srcb_pkg::status_e            status_q;
  logic [srcb_pkg::SLOT_W-1:0]  slot_q;
  logic [IDX_W-1:0]             idx_q, total_q;
  logic [srcb_pkg::ADDR_W-1:0]  addr_q;
  logic [srcb_pkg::LBA_W-1:0]   lba_q;
  logic [srcb_pkg::COUNT_W-1:0] count_q;
  logic [3:0]                   tail_q;   // sectors in the final chunk, less one

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (!slot_found) begin
        status_q <= srcb_pkg::ST_NO_SLOT;
      end else if (!count_ok) begin
        status_q <= srcb_pkg::ST_BAD_COUNT;
      end else begin
        status_q <= srcb_pkg::ST_OK;
      end
      slot_q  <= slot_found ? slot_enc : '0;
      idx_q   <= '0;
      total_q <= req_ok ? total_calc : '0;
      addr_q  <= req_ok ? dest_address_i : '0;
      lba_q   <= req_ok ? lba_start_i : '0;
      count_q <= req_ok ? num_sectors_i : '0;
      tail_q  <= count_m1[3:0];
    end else if (cmd_i.advance) begin
      idx_q  <= idx_q + IDX_W'(1);
      addr_q <= addr_q + srcb_pkg::CHUNK_BYTES;
    end
  end

  logic status_ok, last_chunk;
  assign status_ok  = (status_q == srcb_pkg::ST_OK);
  assign last_chunk = (idx_q + IDX_W'(1)) == total_q;

  assign sts_o.last            = !status_ok || last_chunk;
  assign status_o              = status_q;
  assign slot_o                = slot_q;
  assign entry_index_o         = srcb_pkg::EIDX_W'(idx_q);
  assign entry_total_o         = srcb_pkg::ETOT_W'(total_q);
  assign data_address_o        = addr_q;
  assign block_address_o       = lba_q;
  assign frame_count_o         = count_q;
  // Full chunk reads 8191; the final chunk reads tail*512 + 511
  assign byte_count_less_one_o = !status_ok ? '0 :
                                 last_chunk ? {tail_q, {srcb_pkg::SECTOR_SHIFT{1'b1}}} :
                                              {srcb_pkg::BCL1_W{1'b1}};

endmodule

// ----- sv/sata_read_command_builder.sv -----
// Top level of the SATA read command builder (READ DMA EXT setup).
// Instantiates srcb_ctrl and srcb_dp; depends on srcb_pkg.
//
// Usage:
//   The slave stream takes one read request per item: LBA, sector count,
//   destination address and the active / issued slot masks. The block picks
//   the lowest free command slot among SLOT_COUNT and checks the count
//   against 1 .. MAX_ENTRIES*16 sectors.
//   The master stream gives one descriptor per 16-sector chunk, tlast on the
//   final one. A request with no free slot or a bad count gives a single
//   item carrying the error status, with tlast set.
//   Timing: the first descriptor is valid the cycle after the request is
//   taken, then one descriptor per cycle while tready is high. Descriptors
//   come from the single descriptor register stepped by the controller;
//   the next request is taken once the last item has gone.
//   A stall on the master side holds the current descriptor unchanged.
//   Reset empties the output and leaves the block ready for a request;
//   there is no stored state between requests.
`timescale 1ns / 1ps

module sata_read_command_builder #(
  parameter int unsigned SLOT_COUNT  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] lba_start, [63:48] num_sectors, [127:64] dest_address,
  // [159:128] active_slots, [191:160] issued_slots
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [6:2] slot, [9:7] entry_index, [13:10] entry_total,
  // [77:14] data_address, [90:78] byte_count_less_one,
  // [138:91] block_address, [154:139] frame_count, [159:155] zero
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  srcb_pkg::cmd_t    cmd;
  srcb_pkg::sts_t    sts;
  srcb_pkg::status_e status;

  logic [srcb_pkg::SLOT_W-1:0]  slot;
  logic [srcb_pkg::EIDX_W-1:0]  entry_index;
  logic [srcb_pkg::ETOT_W-1:0]  entry_total;
  logic [srcb_pkg::ADDR_W-1:0]  data_address;
  logic [srcb_pkg::BCL1_W-1:0]  byte_count_less_one;
  logic [srcb_pkg::LBA_W-1:0]   block_address;
  logic [srcb_pkg::COUNT_W-1:0] frame_count;

  srcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  srcb_dp #(
    .SLOT_COUNT  (SLOT_COUNT)
  ) u_dp (
    .clk_i                 (clk_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .lba_start_i           (s_axis_tdata[47:0]),
    .num_sectors_i         (s_axis_tdata[63:48]),
    .dest_address_i        (s_axis_tdata[127:64]),
    .active_slots_i        (s_axis_tdata[159:128]),
    .issued_slots_i        (s_axis_tdata[191:160]),
    .status_o              (status),
    .slot_o                (slot),
    .entry_index_o         (entry_index),
    .entry_total_o         (entry_total),
    .data_address_o        (data_address),
    .byte_count_less_one_o (byte_count_less_one),
    .block_address_o       (block_address),
    .frame_count_o         (frame_count)
  );

  // Output packing
  assign m_axis_tdata = {5'd0, frame_count, block_address, byte_count_less_one,
                         data_address, entry_total, entry_index, slot, status};
  assign m_axis_tlast = sts.last;

  // Request intake and descriptor output never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("intake open while a descriptor is pending");

  // A taken request shows its first item on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (m_axis_tvalid && entry_index == '0))
    else $error("first descriptor missing after request");

  // Error results are always single items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && status != srcb_pkg::ST_OK) |-> m_axis_tlast)
    else $error("error status without tlast");

  // Descriptors of one request count up by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && entry_index == $past(entry_index) + 3'd1))
    else $error("descriptor index did not step");

  // Intake reopens once the final item has gone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("intake not reopened after final descriptor");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for sata_read_command_builder: drives read requests on the
// slave stream and checks each descriptor against a built-in descriptor predictor.
// Depends on srcb_pkg and the sata_read_command_builder RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_ENTRIES       = srcb_pkg::MAX_ENTRIES;
  localparam int unsigned SLOT_COUNT        = 32;
  localparam int unsigned SECTORS_PER_CHUNK = 16;
  localparam int unsigned RANDOM_ITEMS      = 500;
  localparam int unsigned DRAIN_CYCLES      = 20;
  localparam int unsigned WATCHDOG_LIMIT    = 2000;
  localparam int unsigned N_DIRECTED        = 20;

  // One read request, laid out as on s_axis_tdata (last field lowest)
  typedef struct packed {
    logic [srcb_pkg::MASK_W-1:0]  issued;
    logic [srcb_pkg::MASK_W-1:0]  active;
    logic [srcb_pkg::ADDR_W-1:0]  dest;
    logic [srcb_pkg::COUNT_W-1:0] count;
    logic [srcb_pkg::LBA_W-1:0]   lba;
  } request_t;

  // One descriptor, laid out as on m_axis_tdata
  typedef struct packed {
    logic [4:0]                   pad;
    logic [srcb_pkg::COUNT_W-1:0] frame_count;
    logic [srcb_pkg::LBA_W-1:0]   block_address;
    logic [srcb_pkg::BCL1_W-1:0]  bcl1;
    logic [srcb_pkg::ADDR_W-1:0]  data_address;
    logic [srcb_pkg::ETOT_W-1:0]  entry_total;
    logic [srcb_pkg::EIDX_W-1:0]  entry_index;
    logic [srcb_pkg::SLOT_W-1:0]  slot;
    srcb_pkg::status_e            status;
  } descriptor_t;

  typedef struct packed {
    descriptor_t desc;
    logic        last;
  } due_t;

  // Directed stimulus row; typed rows carry their single error item
  typedef struct {
    logic [srcb_pkg::LBA_W-1:0]   lba;
    logic [srcb_pkg::COUNT_W-1:0] count;
    logic [srcb_pkg::ADDR_W-1:0]  dest;
    logic [srcb_pkg::MASK_W-1:0]  active;
    logic [srcb_pkg::MASK_W-1:0]  issued;
    bit                           typed;
    srcb_pkg::status_e            st;
    logic [srcb_pkg::SLOT_W-1:0]  slot;
  } row_t;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         m_axis_tlast;

  due_t        descriptors_due[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          steady       = 1'b0;
  row_t        directed_rows [N_DIRECTED];

  always #5 clk_i = ~clk_i;

  sata_read_command_builder #(
    .SLOT_COUNT (SLOT_COUNT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Descriptor predictor: lowest free slot, count check, one item per chunk
  function automatic void build_descriptors(input request_t req);
    logic [srcb_pkg::MASK_W-1:0] busy;
    int   slot;
    int   total;
    int   left;
    due_t d;
    busy = req.active | req.issued;
    slot = -1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy[i]) slot = i;
    end
    d = '0;
    d.last = 1'b1;
    if (slot < 0) begin
      d.desc.status = srcb_pkg::ST_NO_SLOT;
      descriptors_due.push_back(d);
      return;
    end
    d.desc.slot = srcb_pkg::SLOT_W'(slot);
    if (req.count == 0 || req.count > MAX_ENTRIES * SECTORS_PER_CHUNK) begin
      d.desc.status = srcb_pkg::ST_BAD_COUNT;
      descriptors_due.push_back(d);
      return;
    end
    total = (int'(req.count) - 1) / SECTORS_PER_CHUNK + 1;
    left  = req.count;
    for (int i = 0; i < total; i++) begin
      d.desc.status        = srcb_pkg::ST_OK;
      d.desc.entry_index   = srcb_pkg::EIDX_W'(i);
      d.desc.entry_total   = srcb_pkg::ETOT_W'(total);
      d.desc.data_address  = req.dest + (srcb_pkg::ADDR_W'(i) << 13);
      d.last               = (i == total - 1);
      d.desc.bcl1          = d.last ? srcb_pkg::BCL1_W'(left * 512 - 1) :
                                      {srcb_pkg::BCL1_W{1'b1}};
      d.desc.block_address = req.lba;
      d.desc.frame_count   = req.count;
      descriptors_due.push_back(d);
      left -= SECTORS_PER_CHUNK;
    end
  endfunction

  // Random request: mostly a free slot and a legal count, with some errors mixed in
  function automatic request_t make_request();
    request_t r;
    int       free_slot;
    int       pick;
    r.lba    = {16'($urandom), $urandom};
    r.dest   = {$urandom, $urandom};
    r.active = $urandom;
    r.issued = $urandom;
    pick     = $urandom_range(0, 99);
    if (pick < 80) begin
      free_slot = $urandom_range(0, SLOT_COUNT - 1);
      r.active[free_slot] = 1'b0;
      r.issued[free_slot] = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        r.active &= $urandom;
        r.issued &= $urandom;
      end
    end else if (pick < 88) begin
      r.issued = ~r.active | $urandom;
    end
    if ($urandom_range(0, 99) < 85) begin
      r.count = 16'($urandom_range(1, MAX_ENTRIES * SECTORS_PER_CHUNK));
    end else begin
      r.count = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(129, 65535));
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one request, with random idling before it, and predict on acceptance
  task automatic send_request(input request_t req, input bit typed,
                              input srcb_pkg::status_e st,
                              input logic [srcb_pkg::SLOT_W-1:0] slot);
    due_t d;
    if (!steady && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 35);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (typed) begin
      d             = '0;
      d.desc.status = st;
      d.desc.slot   = slot;
      d.last        = 1'b1;
      descriptors_due.push_back(d);
    end else begin
      build_descriptors(req);
    end
  endtask

  // Result side: check each accepted item, stall at random
  always @(posedge clk_i) begin
    descriptor_t got;
    due_t        want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (descriptors_due.size() == 0) begin
        $error("result item with none expected: tdata 0x%0h", m_axis_tdata);
        mismatches++;
      end else begin
        want = descriptors_due.pop_front();
        check_field("status", want.desc.status, got.status);
        check_field("slot", want.desc.slot, got.slot);
        check_field("entry_index", want.desc.entry_index, got.entry_index);
        check_field("entry_total", want.desc.entry_total, got.entry_total);
        check_field("data_address", want.desc.data_address, got.data_address);
        check_field("byte_count_less_one", want.desc.bcl1, got.bcl1);
        check_field("block_address", want.desc.block_address, got.block_address);
        check_field("frame_count", want.desc.frame_count, got.frame_count);
        check_field("padding", want.desc.pad, got.pad);
        check_field("last", want.last, m_axis_tlast);
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 35);
  end

  // Watchdog: too long without any item moving ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sata_read_command_builder regression: fail");
      $finish;
    end
  end

  initial begin
    request_t req;
    // lba, count, dest, active, issued, typed, status, slot
    directed_rows = '{
      '{48'h0, 16'd1, 64'h0, 32'h0, 32'h0, 1'b0, srcb_pkg::ST_OK, 5'd0},
      // zero count
      '{48'h0, 16'd0, 64'h0, 32'h0, 32'h0, 1'b1, srcb_pkg::ST_BAD_COUNT, 5'd0},
      '{48'h1234_5678_9ABC, 16'd129, 64'h1000, 32'h1, 32'h0,
        1'b1, srcb_pkg::ST_BAD_COUNT, 5'd1},
      '{48'hFFFF_FFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h7,
        1'b1, srcb_pkg::ST_BAD_COUNT, 5'd3},
      '{48'h0, 16'd8, 64'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, srcb_pkg::ST_NO_SLOT, 5'd0},
      '{48'h0, 16'd8, 64'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, srcb_pkg::ST_NO_SLOT, 5'd0},
      // no slot takes precedence over a bad count
      '{48'h0, 16'd0, 64'h0, 32'hFFFF_0000, 32'h0000_FFFF,
        1'b1, srcb_pkg::ST_NO_SLOT, 5'd0},
      '{48'hAAAA_AAAA_AAAA, 16'd16, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
        1'b1, srcb_pkg::ST_NO_SLOT, 5'd0},
      '{48'h5555_5555_5555, 16'd16, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'h0,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      // top slot, full table, address wrap
      '{48'hFFFF_FFFF_FFFF, 16'd128, 64'hFFFF_FFFF_FFFF_F000, 32'h7FFF_FFFF, 32'h0,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'h0, 16'd17, 64'h0, 32'h0, 32'h8000_0000, 1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'h0000_0001_0000, 16'd15, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_00FF, 32'h0000_FF00,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'h1, 16'd112, 64'h8000_0000_0000_0000, 32'h0, 32'h0,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'h2, 16'd113, 64'h0000_0000_0000_0200, 32'h0, 32'h1,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'h3, 16'd127, 64'h7FFF_FFFF_FFFF_FFFF, 32'h3, 32'h0,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'hFFFF_FFFF_FFFF, 16'd128, 64'h0, 32'hFFFF_FFFD, 32'h0,
        1'b0, srcb_pkg::ST_OK, 5'd0},
      '{48'h0, 16'd130, 64'h0, 32'h7FFF_FFFF, 32'h0,
        1'b1, srcb_pkg::ST_BAD_COUNT, 5'd31},
      '{48'h0, 16'h8000, 64'h0, 32'h0, 32'hFFFF_FFFE,
        1'b1, srcb_pkg::ST_BAD_COUNT, 5'd0},
      '{48'h8000_0000_0000, 16'd32, 64'h1FFF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
        1'b1, srcb_pkg::ST_NO_SLOT, 5'd0},
      '{48'h0000_FFFF_0000, 16'd64, 64'h0, 32'h3, 32'h4, 1'b0, srcb_pkg::ST_OK, 5'd0}
    };

    // Reset
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed_rows[k]) begin
      req.lba    = directed_rows[k].lba;
      req.count  = directed_rows[k].count;
      req.dest   = directed_rows[k].dest;
      req.active = directed_rows[k].active;
      req.issued = directed_rows[k].issued;
      send_request(req, directed_rows[k].typed, directed_rows[k].st, directed_rows[k].slot);
    end

    // Random requests; one hold-off until drained, one stretch without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 300 && n < 400);
      if (n == 200) begin
        s_axis_tvalid <= 1'b0;
        while (descriptors_due.size() != 0) @(posedge clk_i);
      end
      send_request(make_request(), 1'b0, srcb_pkg::ST_OK, '0);
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain
    while (descriptors_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && descriptors_due.size() == 0) begin
      $display("sata_read_command_builder regression: pass");
    end else begin
      $display("sata_read_command_builder regression: fail");
    end
    $finish;
  end

endmodule
